@@ hdl/lcs_pkg.sv @@
// Shared types and constants for the lubrication cycle sequencer.
// Used by lcs_cfg_regs, lcs_core and the top level; depends on nothing.
`default_nettype none

package lcs_pkg;

	localparam int CFG_W   = 16;
	localparam int CIDX_W  = 3;
	localparam int SEC_W   = 6;
	localparam int TMIN_W  = 8;
	localparam int MODE_W  = 3;
	localparam int OP_W    = 3;

	localparam logic [SEC_W-1:0]  SECONDS_PER_MINUTE = 6'd60;
	localparam logic [5:0]        LAST_MINUTE        = 6'd59;
	localparam logic [SEC_W-1:0]  TEST_SECONDS_DEF   = 6'd60;
	localparam logic [TMIN_W-1:0] TEST_MINUTES_DEF   = 8'd5;

	localparam logic [MODE_W-1:0] MODE_IDLE  = 3'd0;
	localparam logic [MODE_W-1:0] MODE_LUBE  = 3'd1;
	localparam logic [MODE_W-1:0] MODE_PAUSE = 3'd2;
	localparam logic [MODE_W-1:0] MODE_TEST  = 3'd3;
	localparam logic [MODE_W-1:0] MODE_SLEEP = 3'd4;

	localparam logic [OP_W-1:0] OP_NONE  = 3'd0;
	localparam logic [OP_W-1:0] OP_LUBE  = 3'd1;
	localparam logic [OP_W-1:0] OP_TEST  = 3'd2;
	localparam logic [OP_W-1:0] OP_SLEEP = 3'd3;
	localparam logic [OP_W-1:0] OP_STOP  = 3'd4;

	localparam logic [CIDX_W-1:0] REG_PATTERN_0     = 3'd0;
	localparam logic [CIDX_W-1:0] REG_PATTERN_1     = 3'd1;
	localparam logic [CIDX_W-1:0] REG_PATTERN_2     = 3'd2;
	localparam logic [CIDX_W-1:0] REG_PATTERN_3     = 3'd3;
	localparam logic [CIDX_W-1:0] REG_OUTLET_COUNT  = 3'd4;
	localparam logic [CIDX_W-1:0] REG_DOSE_AMOUNT   = 3'd5;
	localparam logic [CIDX_W-1:0] REG_PAUSE_HOURS   = 3'd6;
	localparam logic [CIDX_W-1:0] REG_PAUSE_MINUTES = 3'd7;

	typedef struct packed {
		logic [3:0][7:0] pattern_word;
		logic [7:0]      outlet_count;
		logic [15:0]     dose_amount;
		logic [7:0]      pause_hours;
		logic [5:0]      pause_minutes;
	} cfg_t;

	typedef struct packed {
		logic [MODE_W-1:0] mode;
		logic              motor_on;
		logic              cycle_done;
		logic              pause_started;
		logic              lubrication_restarted;
		logic              pause_minute_elapsed;
		logic              test_finished;
		logic [7:0]        pause_hours_left;
		logic [5:0]        pause_minutes_left;
		logic [15:0]       sensor_idle_seconds;
		logic [31:0]       total_strokes;
	} res_t;

endpackage

`default_nettype wire

@@ hdl/lcs_cfg_regs.sv @@
// Configuration register file of the lubrication cycle sequencer.
// Depends on lcs_pkg for the register indexes and the cfg_t bundle.
`default_nettype none

module lcs_cfg_regs (
	input  wire logic                        clk,
	input  wire logic                        arst_n,
	input  wire logic                        cfg_we,
	input  wire logic [lcs_pkg::CIDX_W-1:0]  cfg_index,
	input  wire logic [lcs_pkg::CFG_W-1:0]   cfg_data,
	output lcs_pkg::cfg_t                    cfg
);

	lcs_pkg::cfg_t cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.pattern_word  <= {4{8'd1}};
			cfg_q.outlet_count  <= 8'd1;
			cfg_q.dose_amount   <= 16'd0;
			cfg_q.pause_hours   <= 8'd0;
			cfg_q.pause_minutes <= 6'd0;
		end else if (cfg_we) begin
			unique case (cfg_index)
				lcs_pkg::REG_PATTERN_0:     cfg_q.pattern_word[0] <= cfg_data[7:0];
				lcs_pkg::REG_PATTERN_1:     cfg_q.pattern_word[1] <= cfg_data[7:0];
				lcs_pkg::REG_PATTERN_2:     cfg_q.pattern_word[2] <= cfg_data[7:0];
				lcs_pkg::REG_PATTERN_3:     cfg_q.pattern_word[3] <= cfg_data[7:0];
				lcs_pkg::REG_OUTLET_COUNT:  cfg_q.outlet_count    <= cfg_data[7:0];
				lcs_pkg::REG_DOSE_AMOUNT:   cfg_q.dose_amount     <= cfg_data[15:0];
				lcs_pkg::REG_PAUSE_HOURS:   cfg_q.pause_hours     <= cfg_data[7:0];
				lcs_pkg::REG_PAUSE_MINUTES: cfg_q.pause_minutes   <= cfg_data[5:0];
				default: ;
			endcase
		end
	end

	assign cfg = cfg_q;

endmodule

`default_nettype wire

@@ hdl/lcs_core.sv @@
// Sequencer state and the per-item next-state logic of the lubrication
// cycle sequencer. Depends on lcs_pkg; fed by lcs_cfg_regs.
`default_nettype none

module lcs_core #(
	parameter logic [lcs_pkg::SEC_W-1:0]  TEST_SECONDS = lcs_pkg::TEST_SECONDS_DEF,
	parameter logic [lcs_pkg::TMIN_W-1:0] TEST_MINUTES = lcs_pkg::TEST_MINUTES_DEF
) (
	input  wire logic                        clk,
	input  wire logic                        arst_n,
	input  wire logic                        step_en,
	input  wire logic [lcs_pkg::OP_W-1:0]    op,
	input  wire logic                        second_tick,
	input  wire logic                        sensor_active,
	input  lcs_pkg::cfg_t                    cfg,
	output lcs_pkg::res_t                    res
);

	logic [lcs_pkg::MODE_W-1:0] mode_q, mode_d, mode_cmd;
	logic                       latched_q, latched_d;
	logic [7:0]                 strokes_q, strokes_d, strokes_inc;
	logic [1:0]                 pidx_q, pidx_d;
	logic [15:0]                dose_q, dose_d, dose_sub;
	logic [16:0]                dose_sum;
	logic [lcs_pkg::SEC_W-1:0]  psec_q, psec_d;
	logic [5:0]                 pmin_q, pmin_d;
	logic [7:0]                 phr_q, phr_d;
	logic [lcs_pkg::SEC_W-1:0]  tsec_q, tsec_d;
	logic [lcs_pkg::TMIN_W-1:0] tmin_q, tmin_d;
	logic [15:0]                idle_q, idle_d;
	logic [31:0]                total_q, total_d;
	logic                       press, pattern_hit, test_over;
	logic                       cycle_done, pause_started, restarted, minute_elapsed;
	logic                       test_finished;

	// Command decode; unknown codes leave the mode alone.
	always_comb begin
		unique case (op)
			lcs_pkg::OP_LUBE:  mode_cmd = lcs_pkg::MODE_LUBE;
			lcs_pkg::OP_TEST:  mode_cmd = lcs_pkg::MODE_TEST;
			lcs_pkg::OP_SLEEP: mode_cmd = lcs_pkg::MODE_SLEEP;
			lcs_pkg::OP_STOP:  mode_cmd = lcs_pkg::MODE_IDLE;
			default:           mode_cmd = mode_q;
		endcase
	end

	always_comb begin
		mode_d         = mode_cmd;
		latched_d      = latched_q;
		strokes_d      = strokes_q;
		pidx_d         = pidx_q;
		dose_d         = dose_q;
		psec_d         = psec_q;
		pmin_d         = pmin_q;
		phr_d          = phr_q;
		tsec_d         = tsec_q;
		tmin_d         = tmin_q;
		idle_d         = idle_q;
		total_d        = total_q;
		test_over      = 1'b0;
		cycle_done     = 1'b0;
		pause_started  = 1'b0;
		restarted      = 1'b0;
		minute_elapsed = 1'b0;
		test_finished  = 1'b0;

		// Second tick work happens on the mode chosen by this item's command.
		if (second_tick) begin
			if ((mode_cmd == lcs_pkg::MODE_LUBE || mode_cmd == lcs_pkg::MODE_TEST) &&
			    idle_q != 16'hFFFF) begin
				idle_d = idle_q + 16'd1;
			end
			if (mode_cmd == lcs_pkg::MODE_PAUSE && psec_q != '0) begin
				psec_d = psec_q - lcs_pkg::SEC_W'(1);
			end
			if (mode_cmd == lcs_pkg::MODE_TEST) begin
				if (tsec_q <= lcs_pkg::SEC_W'(1)) begin
					tsec_d = lcs_pkg::SECONDS_PER_MINUTE;
					if (tmin_q == '0) begin
						test_over = 1'b1;
					end else begin
						tmin_d = tmin_q - lcs_pkg::TMIN_W'(1);
					end
				end else begin
					tsec_d = tsec_q - lcs_pkg::SEC_W'(1);
				end
			end
		end

		// A stroke counts only on the rising sensor level, and only while the
		// pump runs; the latch then simply follows the sensor.
		press       = sensor_active && !latched_q;
		strokes_inc = strokes_q + 8'd1;
		pattern_hit = strokes_inc >= cfg.pattern_word[pidx_q];
		dose_sub    = (dose_q >= {8'd0, cfg.outlet_count}) ?
		              dose_q - {8'd0, cfg.outlet_count} : 16'd0;
		dose_sum    = {1'b0, dose_sub} + {1'b0, cfg.dose_amount};

		if (mode_cmd == lcs_pkg::MODE_LUBE || mode_cmd == lcs_pkg::MODE_TEST) begin
			latched_d = sensor_active;
			if (press) begin
				idle_d = 16'd0;
				if (pattern_hit) begin
					strokes_d  = 8'd0;
					pidx_d     = pidx_q + 2'd1;
					cycle_done = 1'b1;
				end else begin
					strokes_d = strokes_inc;
				end
			end
		end

		if (mode_cmd == lcs_pkg::MODE_LUBE) begin
			if (press) begin
				total_d = total_q + 32'd1;
				if (pattern_hit) begin
					dose_d = dose_sub;
					if (dose_sub < {8'd0, cfg.outlet_count}) begin
						dose_d        = dose_sum[16] ? 16'hFFFF : dose_sum[15:0];
						mode_d        = lcs_pkg::MODE_PAUSE;
						psec_d        = lcs_pkg::SECONDS_PER_MINUTE;
						pmin_d        = cfg.pause_minutes;
						phr_d         = cfg.pause_hours;
						pause_started = 1'b1;
					end
				end
			end
		end else if (mode_cmd == lcs_pkg::MODE_PAUSE) begin
			if (psec_d == '0) begin
				psec_d         = lcs_pkg::SECONDS_PER_MINUTE;
				minute_elapsed = 1'b1;
				if (pmin_q == '0) begin
					if (phr_q != '0) begin
						pmin_d = lcs_pkg::LAST_MINUTE;
						phr_d  = phr_q - 8'd1;
					end
				end else begin
					pmin_d = pmin_q - 6'd1;
				end
			end
			if (phr_d == '0 && pmin_d == '0) begin
				mode_d    = lcs_pkg::MODE_LUBE;
				pmin_d    = cfg.pause_minutes;
				phr_d     = cfg.pause_hours;
				restarted = 1'b1;
			end
		end else if (mode_cmd == lcs_pkg::MODE_TEST) begin
			if (test_over) begin
				tsec_d        = TEST_SECONDS;
				tmin_d        = TEST_MINUTES;
				mode_d        = lcs_pkg::MODE_IDLE;
				idle_d        = 16'd0;
				test_finished = 1'b1;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q    <= lcs_pkg::MODE_IDLE;
			latched_q <= 1'b0;
			strokes_q <= 8'd0;
			pidx_q    <= 2'd0;
			dose_q    <= 16'd0;
			psec_q    <= lcs_pkg::SECONDS_PER_MINUTE;
			pmin_q    <= 6'd0;
			phr_q     <= 8'd0;
			tsec_q    <= TEST_SECONDS;
			tmin_q    <= TEST_MINUTES;
			idle_q    <= 16'd0;
			total_q   <= 32'd0;
		end else if (step_en) begin
			mode_q    <= mode_d;
			latched_q <= latched_d;
			strokes_q <= strokes_d;
			pidx_q    <= pidx_d;
			dose_q    <= dose_d;
			psec_q    <= psec_d;
			pmin_q    <= pmin_d;
			phr_q     <= phr_d;
			tsec_q    <= tsec_d;
			tmin_q    <= tmin_d;
			idle_q    <= idle_d;
			total_q   <= total_d;
		end
	end

	always_comb begin
		res.mode                  = mode_d;
		res.motor_on              = mode_d == lcs_pkg::MODE_LUBE || mode_d == lcs_pkg::MODE_TEST;
		res.cycle_done            = cycle_done;
		res.pause_started         = pause_started;
		res.lubrication_restarted = restarted;
		res.pause_minute_elapsed  = minute_elapsed;
		res.test_finished         = test_finished;
		res.pause_hours_left      = phr_d;
		res.pause_minutes_left    = pmin_d;
		res.sensor_idle_seconds   = idle_d;
		res.total_strokes         = total_d;
	end

	// The pause countdown never leaves its seconds register past a full minute.
	a_psec_range: assert property (@(posedge clk) disable iff (!arst_n)
		psec_q <= lcs_pkg::SECONDS_PER_MINUTE)
		else $error("pause second count out of range");

	// Test seconds never sit at zero; a finished minute reloads them.
	a_tsec_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		tsec_q != '0)
		else $error("test second count reached zero");

	// In idle mode nothing is counted: the stroke total and the dose hold.
	a_idle_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(step_en && mode_cmd == lcs_pkg::MODE_IDLE) |=> $stable(total_q) && $stable(dose_q))
		else $error("counters moved while idle");

endmodule

`default_nettype wire

@@ hdl/lubrication_cycle_sequencer.sv @@
// Lubrication cycle sequencer: accepts one sample per item (command, second
// tick, proximity sensor level) and returns one status item per sample.
//
// Input items arrive on in_valid/in_ready with op, second_tick and
// sensor_active; results leave on out_valid/out_ready with the mode, the
// motor drive, the event flags and the pause, idle and stroke counters.
// An item is first captured in an input register; once the output register
// can take a result, the sequencer state is stepped and the result lands in
// the output register, raising out_valid; one item is accepted in every
// cycle while the receiver keeps up.
// When the receiver stalls, the held result and one item in the input
// register wait; in_ready drops only when both are occupied.
// The user writes configuration via cfg_we, cfg_index and cfg_data only while
// the block is idle (not enforced); a write takes effect at the clock edge.
// Reset puts the block in idle with all counters cleared, the pause and test
// countdowns loaded, every pattern word and the outlet count at one.
// Depends on lcs_pkg, lcs_cfg_regs and lcs_core.
`default_nettype none

module lubrication_cycle_sequencer #(
	parameter logic [lcs_pkg::SEC_W-1:0]  TEST_SECONDS = lcs_pkg::TEST_SECONDS_DEF,
	parameter logic [lcs_pkg::TMIN_W-1:0] TEST_MINUTES = lcs_pkg::TEST_MINUTES_DEF
) (
	input  wire logic                        clk,
	input  wire logic                        arst_n,
	input  wire logic                        cfg_we,
	input  wire logic [lcs_pkg::CIDX_W-1:0]  cfg_index,
	input  wire logic [lcs_pkg::CFG_W-1:0]   cfg_data,
	input  wire logic                        in_valid,
	output wire logic                        in_ready,
	input  wire logic [lcs_pkg::OP_W-1:0]    op,
	input  wire logic                        second_tick,
	input  wire logic                        sensor_active,
	output wire logic                        out_valid,
	input  wire logic                        out_ready,
	output wire logic [lcs_pkg::MODE_W-1:0]  mode,
	output wire logic                        motor_on,
	output wire logic                        cycle_done,
	output wire logic                        pause_started,
	output wire logic                        lubrication_restarted,
	output wire logic                        pause_minute_elapsed,
	output wire logic                        test_finished,
	output wire logic [7:0]                  pause_hours_left,
	output wire logic [5:0]                  pause_minutes_left,
	output wire logic [15:0]                 sensor_idle_seconds,
	output wire logic [31:0]                 total_strokes
);

	lcs_pkg::cfg_t              cfg;
	lcs_pkg::res_t              res, res_s2;
	logic                       valid_s1, valid_s2;
	logic [lcs_pkg::OP_W-1:0]   op_s1;
	logic                       tick_s1, sensor_s1;
	logic                       advance, step_en;

	assign advance  = !valid_s2 || out_ready;
	assign in_ready = !valid_s1 || advance;
	assign step_en  = valid_s1 && advance;

	lcs_cfg_regs u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.cfg       (cfg)
	);

	lcs_core #(
		.TEST_SECONDS (TEST_SECONDS),
		.TEST_MINUTES (TEST_MINUTES)
	) u_core (
		.clk           (clk),
		.arst_n        (arst_n),
		.step_en       (step_en),
		.op            (op_s1),
		.second_tick   (tick_s1),
		.sensor_active (sensor_s1),
		.cfg           (cfg),
		.res           (res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else begin
			if (in_ready) begin
				valid_s1 <= in_valid;
			end
			if (advance) begin
				valid_s2 <= valid_s1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			op_s1     <= op;
			tick_s1   <= second_tick;
			sensor_s1 <= sensor_active;
		end
		if (step_en) begin
			res_s2 <= res;
		end
	end

	assign out_valid             = valid_s2;
	assign mode                  = res_s2.mode;
	assign motor_on              = res_s2.motor_on;
	assign cycle_done            = res_s2.cycle_done;
	assign pause_started         = res_s2.pause_started;
	assign lubrication_restarted = res_s2.lubrication_restarted;
	assign pause_minute_elapsed  = res_s2.pause_minute_elapsed;
	assign test_finished         = res_s2.test_finished;
	assign pause_hours_left      = res_s2.pause_hours_left;
	assign pause_minutes_left    = res_s2.pause_minutes_left;
	assign sensor_idle_seconds   = res_s2.sensor_idle_seconds;
	assign total_strokes         = res_s2.total_strokes;

	// A pause only begins on a completed pattern.
	a_pause_on_cycle: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s2 && res_s2.pause_started) |->
		(res_s2.cycle_done && res_s2.mode == lcs_pkg::MODE_PAUSE))
		else $error("pause started without a completed pattern");

	// A restart leaves the block lubricating with the motor running.
	a_restart_mode: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s2 && res_s2.lubrication_restarted) |->
		(res_s2.mode == lcs_pkg::MODE_LUBE && res_s2.motor_on))
		else $error("restart flagged outside lubrication");

	// A finished test run leaves the block idle with the idle timer cleared.
	a_test_done_idle: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s2 && res_s2.test_finished) |->
		(res_s2.mode == lcs_pkg::MODE_IDLE && res_s2.sensor_idle_seconds == 16'd0))
		else $error("test finished but block not idle");

	// A held result with an item waiting behind it must block new input.
	a_full_blocks: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s1 && valid_s2 && !out_ready) |-> !in_ready)
		else $error("input accepted while both stages are full");

endmodule

`default_nettype wire
